/* hw/rtl/u8d_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POINT_W = 21;
   localparam int unsigned COUNT_W = 2;
   localparam int unsigned BITS_PER_CONT = 6;

   // Lead byte prefixes, compared against the top bits of the byte
   localparam logic [2:0] LEAD2_PREFIX = 3'b110;
   localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
   localparam logic [4:0] LEAD4_PREFIX = 5'b11110;

   localparam logic [POINT_W-1:0] REPLACEMENT_POINT = 21'h00FFFD;

   localparam logic [COUNT_W-1:0] NEED_NONE  = 2'd0;
   localparam logic [COUNT_W-1:0] NEED_ONE   = 2'd1;
   localparam logic [COUNT_W-1:0] NEED_TWO   = 2'd2;
   localparam logic [COUNT_W-1:0] NEED_THREE = 2'd3;

   // One decoded code point on its way to the result register
   typedef struct packed {
      logic [POINT_W-1:0] code_point;
      logic               last_point;
   } result_type;

endpackage

/* hw/rtl/u8d_if.sv */
// Request and response channel interfaces of the UTF-8 stream decoder.
interface u8d_req_if;
   logic                       valid;
   logic                       ready;
   logic [u8d_pkg::BYTE_W-1:0] byte_in;
   logic                       string_end;

   modport source (output valid, output byte_in, output string_end, input ready);
   modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

interface u8d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [u8d_pkg::POINT_W-1:0] code_point;
   logic                        last_point;

   modport source (output valid, output code_point, output last_point, input ready);
   modport sink   (input valid, input code_point, input last_point, output ready);
endinterface

/* hw/rtl/u8d_decode.sv */
// Per-byte decode step and the open-sequence state registers.
module u8d_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [u8d_pkg::BYTE_W-1:0]  byte_in,
   input  logic                        string_end,
   output logic                        emit,
   output u8d_pkg::result_type         result
);

   logic [u8d_pkg::POINT_W-1:0] partial_ff, partial_in;
   logic [u8d_pkg::COUNT_W-1:0] remain_ff, remain_in;
   logic [u8d_pkg::POINT_W-1:0] point;
   logic [u8d_pkg::COUNT_W-1:0] need;

   // Classify a lead byte or shift in a continuation byte
   always_comb begin
      point = '0;
      need  = u8d_pkg::NEED_NONE;
      if (remain_ff == u8d_pkg::NEED_NONE) begin
         if (byte_in[7] == 1'b0) begin
            point = {13'd0, byte_in};
         end else if (byte_in[7:5] == u8d_pkg::LEAD2_PREFIX) begin
            point = {16'd0, byte_in[4:0]};
            need  = u8d_pkg::NEED_ONE;
         end else if (byte_in[7:4] == u8d_pkg::LEAD3_PREFIX) begin
            point = {17'd0, byte_in[3:0]};
            need  = u8d_pkg::NEED_TWO;
         end else if (byte_in[7:3] == u8d_pkg::LEAD4_PREFIX) begin
            point = {18'd0, byte_in[2:0]};
            need  = u8d_pkg::NEED_THREE;
         end else begin
            point = u8d_pkg::REPLACEMENT_POINT;
         end
      end else begin
         point = {partial_ff[u8d_pkg::POINT_W-u8d_pkg::BITS_PER_CONT-1:0], byte_in[5:0]};
         need  = remain_ff - 2'd1;
      end
   end

   // Emit when the sequence completes or the string closes
   assign emit              = (need == u8d_pkg::NEED_NONE) || string_end;
   assign result.code_point = point;
   assign result.last_point = string_end;

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      if (step) begin
         if (emit) begin
            partial_in = '0;
            remain_in  = u8d_pkg::NEED_NONE;
         end else begin
            partial_in = point;
            remain_in  = need;
         end
      end
   end

   // Hold the open sequence across bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= u8d_pkg::NEED_NONE;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
      end
   end

   // An open sequence never holds more than fifteen gathered bits
   assert property (@(posedge clock) disable iff (reset)
      remain_ff != u8d_pkg::NEED_NONE |-> partial_ff[u8d_pkg::POINT_W-1:15] == '0)
      else $error("partial code point too wide for open sequence");

   // An emitted code point closes the sequence
   assert property (@(posedge clock) disable iff (reset)
      step && emit |=> remain_ff == u8d_pkg::NEED_NONE && partial_ff == '0)
      else $error("sequence still open after emit");

endmodule

/* hw/rtl/u8d_out_reg.sv */
// Result register that drives the response channel.
module u8d_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  u8d_pkg::result_type result,
   output logic                busy,
   u8d_rsp_if.source           rsp_chan
);

   logic                valid_ff, valid_in;
   u8d_pkg::result_type data_ff, data_in;

   // Keep the result until taken; a load only comes when the slot frees
   assign valid_in = load || (valid_ff && !rsp_chan.ready);
   assign data_in  = load ? result : data_ff;
   assign busy     = valid_ff && !rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_point = data_ff.code_point;
   assign rsp_chan.last_point = data_ff.last_point;

endmodule

/* hw/rtl/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder.
//
// Usage:
//   req_chan carries one raw byte of a UTF-8 string per request, with
//   string_end set on the final byte of the string. rsp_chan carries the
//   decoded code points, each with last_point set on the final one.
//   A request is taken when valid and ready are both high at a clock edge.
//   A byte that completes a code point waits in the input register; its
//   response becomes valid when the decode step loads the result register.
//   Throughput: one byte per cycle while no response is stalled, set by the
//   single decode step between the input register and the result register.
//   Bytes that only extend a sequence give no response and never wait on
//   the response side. A byte that gives a response waits in the input
//   register while the result register is held by a stalled receiver; a
//   new request is refused only then.
//   Reset (synchronous, active high) empties both registers and drops any
//   open sequence.
module utf8_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   u8d_req_if.sink    req_chan,
   u8d_rsp_if.source  rsp_chan
);

   logic                       in_valid_ff, in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic                       in_end_ff, in_end_in;
   logic                       emit;
   logic                       out_busy;
   logic                       step;
   logic                       req_take;
   u8d_pkg::result_type        result;

   // Advance the held byte unless its result would hit a stalled slot
   assign step     = in_valid_ff && !(emit && out_busy);
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_take || (in_valid_ff && !step);
   assign in_byte_in  = req_take ? req_chan.byte_in    : in_byte_ff;
   assign in_end_in   = req_take ? req_chan.string_end : in_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

   u8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_in    (in_byte_ff),
      .string_end (in_end_ff),
      .emit       (emit),
      .result     (result)
   );

   u8d_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && emit),
      .result   (result),
      .busy     (out_busy),
      .rsp_chan (rsp_chan)
   );

   // A held byte that is blocked stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff))
      else $error("blocked request lost from input register");

   // A result never overwrites one the receiver has not taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !(step && emit))
      else $error("result register overwritten while stalled");

endmodule
